/* rtl/median_filter_3x3_stream_unit_defines.svh */
// assertion macros for the 3x3 median filter stream unit
// expects clk and rst_n in the scope where a macro is used
`ifndef MEDIAN_FILTER_3X3_STREAM_UNIT_DEFINES_SVH
`define MEDIAN_FILTER_3X3_STREAM_UNIT_DEFINES_SVH

// same-cycle implication
`define MEDF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MEDF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/medf_pkg.sv */
// shared types and constants for the 3x3 median filter stream unit
// no dependencies
package medf_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int PIXEL_BITS_DEF = 8;
  localparam int CFG_W          = 12;
  localparam int CNT_W          = 13;
  localparam int MQ_DEPTH       = 4;
  localparam int OQ_DEPTH       = 4;

  localparam logic [CFG_W-1:0] ROWS_RESET = 12'd720;
  localparam logic [CFG_W-1:0] COLS_RESET = 12'd1280;
  localparam logic [1:0]       ROT_RESET  = 2'd2;

  typedef enum logic [0:0] {
    CFG_FRAME_ROWS = 1'b0,
    CFG_FRAME_COLS = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_FLUSH = 1'b1
  } req_t;

  // per-column control that travels with the window column
  typedef struct packed {
    logic clear;
    logic last;
  } colctl_t;

endpackage

/* rtl/median_filter_3x3_stream_unit.sv */
// 3x3 median filter over a raster pixel stream
// uses medf_pkg, medf_front, medf_fifo, medf_back and the assertion macro header
//
// input channel: in_push / in_full with in_req_type and in_pixel. pixel requests
// (type 0) carry the image in raster order; after the last image row one row of
// flush requests (type 1) emits the zero-padded bottom output row. requests that
// do not fit the frame position are taken and dropped. the first image row
// only fills the line stores.
// result channel: out_empty / out_pop with out_pixel and out_frame_last, which
// marks the final result of a frame. one result per pixel from the second row on.
// config: cfg_we with cfg_addr (0 frame_rows, 1 frame_cols) and cfg_wdata, to be
// written only while the block is idle; the block itself does not enforce this.
// throughput: one request per cycle while in_full is low; each of the three line
// stores does one read and one write per cycle, and the column and result queues
// hold four entries.
// reset: frame size returns to 720 x 1280, position counters and queues clear;
// the line stores are not cleared.
// a stalled receiver fills the result queue, then the column queue, then in_full
// rises; nothing is lost.
`include "median_filter_3x3_stream_unit_defines.svh"

module median_filter_3x3_stream_unit #(
  parameter int MAX_WIDTH  = medf_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = medf_pkg::PIXEL_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  medf_pkg::cfg_idx_t         cfg_addr,
  input  logic [medf_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                       in_push,
  input  logic                       in_req_type,
  input  logic [PIXEL_BITS-1:0]      in_pixel,
  output logic                       in_full,
  input  logic                       out_pop,
  output logic                       out_empty,
  output logic [PIXEL_BITS-1:0]      out_pixel,
  output logic                       out_frame_last
);

  import medf_pkg::*;

  localparam int MQW = 3 * PIXEL_BITS + $bits(colctl_t);
  localparam int OQW = PIXEL_BITS + 1;
  localparam int MCW = $clog2(MQ_DEPTH + 1);
  localparam int OCW = $clog2(OQ_DEPTH + 1);

  logic                  mq_push, mq_pop, mq_empty;
  logic [MCW-1:0]        mq_count;
  logic [PIXEL_BITS-1:0] f_top, f_mid, f_btm;
  colctl_t               f_ctl;
  logic [MQW-1:0]        mq_din, mq_dout;
  logic [PIXEL_BITS-1:0] h_top, h_mid, h_btm;
  colctl_t               h_ctl;

  logic                  oq_push, oq_pop, oq_last;
  logic [OCW-1:0]        oq_count;
  logic [PIXEL_BITS-1:0] oq_pixel;
  logic [OQW-1:0]        oq_din, oq_dout;

  medf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_push     (in_push),
    .in_req_type (in_req_type),
    .in_pixel    (in_pixel),
    .in_full     (in_full),
    .mq_count    (mq_count),
    .mq_push     (mq_push),
    .mq_top      (f_top),
    .mq_mid      (f_mid),
    .mq_btm      (f_btm),
    .mq_ctl      (f_ctl)
  );

  assign mq_din = {f_ctl, f_top, f_mid, f_btm};

  medf_fifo #(
    .DW    (MQW),
    .DEPTH (MQ_DEPTH)
  ) u_col_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mq_push),
    .din   (mq_din),
    .pop   (mq_pop),
    .dout  (mq_dout),
    .empty (mq_empty),
    .count (mq_count)
  );

  assign {h_ctl, h_top, h_mid, h_btm} = mq_dout;

  medf_back #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .mq_empty (mq_empty),
    .mq_top   (h_top),
    .mq_mid   (h_mid),
    .mq_btm   (h_btm),
    .mq_ctl   (h_ctl),
    .mq_pop   (mq_pop),
    .oq_count (oq_count),
    .oq_push  (oq_push),
    .oq_pixel (oq_pixel),
    .oq_last  (oq_last)
  );

  assign oq_din = {oq_last, oq_pixel};
  assign oq_pop = out_pop && !out_empty;

  medf_fifo #(
    .DW    (OQW),
    .DEPTH (OQ_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .din   (oq_din),
    .pop   (oq_pop),
    .dout  (oq_dout),
    .empty (out_empty),
    .count (oq_count)
  );

  assign {out_frame_last, out_pixel} = oq_dout;

  // credit checks: the fetch stage and the back pipeline never overrun a queue
  `MEDF_ASSERT_IMP(a_col_q_room, mq_push && !mq_pop, mq_count < MCW'(MQ_DEPTH), "column queue overrun")
  `MEDF_ASSERT_IMP(a_res_q_room, oq_push && !oq_pop, oq_count < OCW'(OQ_DEPTH), "result queue overrun")
  `MEDF_ASSERT_NXT(a_res_visible, oq_push, !out_empty, "result not visible after push")

endmodule

/* rtl/medf_fifo.sv */
// small register queue with occupancy count
// depends on nothing
module medf_fifo #(
  parameter int DW    = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [DW-1:0]                din,
  input  logic                         pop,
  output logic [DW-1:0]                dout,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PW_ = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW_ = $clog2(DEPTH + 1);

  logic [DW-1:0]  mem_r [DEPTH];
  logic [PW_-1:0] wptr_r, wptr_nxt;
  logic [PW_-1:0] rptr_r, rptr_nxt;
  logic [CW_-1:0] count_r, count_nxt;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW_'(DEPTH - 1)) ? '0 : wptr_r + PW_'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PW_'(DEPTH - 1)) ? '0 : rptr_r + PW_'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW_'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW_'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= din;
    end
  end

  assign dout  = mem_r[rptr_r];
  assign empty = (count_r == '0);
  assign count = count_r;

endmodule

/* rtl/medf_front.sv */
// front end: frame position tracking, line stores and column fetch
// uses medf_pkg; feeds the column queue
module medf_front #(
  parameter int MAX_WIDTH  = medf_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = medf_pkg::PIXEL_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  medf_pkg::cfg_idx_t                     cfg_addr,
  input  logic [medf_pkg::CFG_W-1:0]             cfg_wdata,
  input  logic                                   in_push,
  input  logic                                   in_req_type,
  input  logic [PIXEL_BITS-1:0]                  in_pixel,
  output logic                                   in_full,
  input  logic [$clog2(medf_pkg::MQ_DEPTH+1)-1:0] mq_count,
  output logic                                   mq_push,
  output logic [PIXEL_BITS-1:0]                  mq_top,
  output logic [PIXEL_BITS-1:0]                  mq_mid,
  output logic [PIXEL_BITS-1:0]                  mq_btm,
  output medf_pkg::colctl_t                      mq_ctl
);

  import medf_pkg::*;

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int EW  = CNT_W + 1;
  localparam int QCW = $clog2(MQ_DEPTH + 1);

  logic [CFG_W-1:0] frame_rows_r, frame_cols_r;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic [CNT_W-1:0] col_r, col_nxt;
  logic [1:0]       rot_r, rot_nxt;

  logic                  f1_v_r;
  logic [1:0]            f1_rot_r;
  logic [PIXEL_BITS-1:0] f1_btm_r;
  colctl_t               f1_ctl_r;

  logic [CNT_W-1:0]      rows_eff, cols_nz, cols_eff;
  logic [AW-1:0]         idx;
  logic [1:0]            rot_eff;
  logic                  accept, is_flush, first_row, flush_row, row_end;
  logic                  take0, emit;
  logic [PIXEL_BITS-1:0] store_pix;
  logic [2:0]            line_we;
  logic [PIXEL_BITS-1:0] line_wd [3];
  logic [PIXEL_BITS-1:0] line_rd [3];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_rows_r <= ROWS_RESET;
      frame_cols_r <= COLS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_FRAME_ROWS: frame_rows_r <= cfg_wdata;
        CFG_FRAME_COLS: frame_cols_r <= cfg_wdata;
        default:        frame_rows_r <= frame_rows_r;
      endcase
    end
  end

  // classify the request against the frame position
  always_comb begin
    rows_eff  = (frame_rows_r == '0) ? CNT_W'(1) : CNT_W'(frame_rows_r);
    cols_nz   = (frame_cols_r == '0) ? CNT_W'(1) : CNT_W'(frame_cols_r);
    cols_eff  = (cols_nz > CNT_W'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH) : cols_nz;
    idx       = (col_r >= CNT_W'(MAX_WIDTH)) ? AW'(MAX_WIDTH - 1) : col_r[AW-1:0];
    row_end   = (EW'(col_r) + EW'(1)) >= EW'(cols_eff);
    first_row = (row_r == '0);
    flush_row = (row_r >= rows_eff);
    rot_eff   = (rot_r > 2'd2) ? 2'd2 : rot_r;
    accept    = in_push && !in_full;
    is_flush  = (in_req_type == REQ_FLUSH);
    take0     = accept && first_row && !is_flush;
    emit      = accept && !first_row && (is_flush == flush_row);
    store_pix = flush_row ? '0 : in_pixel;
  end

  // line store writes: first row primes the top and middle lines
  always_comb begin
    for (int g = 0; g < 3; g++) begin
      if (take0) begin
        line_we[g] = (g < 2);
        line_wd[g] = (g == 1) ? in_pixel : '0;
      end else begin
        line_we[g] = emit && (rot_eff == 2'(g));
        line_wd[g] = store_pix;
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_line
    logic [PIXEL_BITS-1:0] mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] rd_r;

    always_ff @(posedge clk) begin
      if (line_we[g]) begin
        mem[idx] <= line_wd[g];
      end
      if (accept) begin
        rd_r <= mem[idx];
      end
    end

    assign line_rd[g] = rd_r;
  end

  // position counters
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    rot_nxt = rot_r;
    if (take0) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = CNT_W'(1);
        rot_nxt = ROT_RESET;
      end else begin
        col_nxt = col_r + CNT_W'(1);
      end
    end else if (emit) begin
      if (row_end) begin
        col_nxt = '0;
        if (flush_row) begin
          row_nxt = '0;
          rot_nxt = ROT_RESET;
        end else begin
          row_nxt = row_r + CNT_W'(1);
          rot_nxt = (rot_eff == 2'd2) ? 2'd0 : rot_eff + 2'd1;
        end
      end else begin
        col_nxt = col_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      rot_r  <= ROT_RESET;
      f1_v_r <= 1'b0;
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      rot_r  <= rot_nxt;
      f1_v_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      f1_rot_r       <= rot_eff;
      f1_btm_r       <= store_pix;
      f1_ctl_r.clear <= (col_r == '0);
      f1_ctl_r.last  <= flush_row && row_end;
    end
  end

  // top line is rotation+1, middle is rotation+2, modulo three
  always_comb begin
    unique case (f1_rot_r)
      2'd0: begin
        mq_top = line_rd[1];
        mq_mid = line_rd[2];
      end
      2'd1: begin
        mq_top = line_rd[2];
        mq_mid = line_rd[0];
      end
      default: begin
        mq_top = line_rd[0];
        mq_mid = line_rd[1];
      end
    endcase
  end

  assign mq_push = f1_v_r;
  assign mq_btm  = f1_btm_r;
  assign mq_ctl  = f1_ctl_r;

  // reserve a queue slot for the column still in the fetch stage
  assign in_full = (QCW + 1)'(mq_count) + (QCW + 1)'(f1_v_r) >= (QCW + 1)'(MQ_DEPTH);

endmodule

/* rtl/medf_back.sv */
// back end: column sort, window shift and median select
// uses medf_pkg; drains the column queue into the result queue
module medf_back #(
  parameter int PIXEL_BITS = medf_pkg::PIXEL_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   mq_empty,
  input  logic [PIXEL_BITS-1:0]                  mq_top,
  input  logic [PIXEL_BITS-1:0]                  mq_mid,
  input  logic [PIXEL_BITS-1:0]                  mq_btm,
  input  medf_pkg::colctl_t                      mq_ctl,
  output logic                                   mq_pop,
  input  logic [$clog2(medf_pkg::OQ_DEPTH+1)-1:0] oq_count,
  output logic                                   oq_push,
  output logic [PIXEL_BITS-1:0]                  oq_pixel,
  output logic                                   oq_last
);

  import medf_pkg::*;

  localparam int OCW = $clog2(OQ_DEPTH + 1);

  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef logic [2:0][PIXEL_BITS-1:0] colv_t;  // [0] low, [1] middle, [2] high

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  logic    s1_v_r, s2_v_r, s2_last_r;
  colv_t   s1_col_r;
  colctl_t s1_ctl_r;
  pix_t    s2_lo_r, s2_md_r, s2_hi_r;
  colv_t   c0_r, c1_r;

  colv_t   head_sorted, a_col, b_col;

  // only pop when the result queue can hold everything in flight
  assign mq_pop = !mq_empty &&
                  ((OCW + 1)'(oq_count) + (OCW + 1)'(s1_v_r) + (OCW + 1)'(s2_v_r)
                   < (OCW + 1)'(OQ_DEPTH));

  always_comb begin
    head_sorted[0] = min2(min2(mq_top, mq_mid), mq_btm);
    head_sorted[1] = med3(mq_top, mq_mid, mq_btm);
    head_sorted[2] = max2(max2(mq_top, mq_mid), mq_btm);
    a_col = s1_ctl_r.clear ? '0 : c0_r;
    b_col = s1_ctl_r.clear ? '0 : c1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      c0_r   <= '0;
      c1_r   <= '0;
    end else begin
      s1_v_r <= mq_pop;
      s2_v_r <= s1_v_r;
      if (s1_v_r) begin
        c0_r <= b_col;
        c1_r <= s1_col_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mq_pop) begin
      s1_col_r <= head_sorted;
      s1_ctl_r <= mq_ctl;
    end
    // median of nine from sorted columns
    if (s1_v_r) begin
      s2_lo_r   <= max2(max2(a_col[0], b_col[0]), s1_col_r[0]);
      s2_md_r   <= med3(a_col[1], b_col[1], s1_col_r[1]);
      s2_hi_r   <= min2(min2(a_col[2], b_col[2]), s1_col_r[2]);
      s2_last_r <= s1_ctl_r.last;
    end
  end

  assign oq_push  = s2_v_r;
  assign oq_pixel = med3(s2_lo_r, s2_md_r, s2_hi_r);
  assign oq_last  = s2_last_r;

endmodule
